/* rtl/core/assert_macros.svh */
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk and disabled in reset.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define MIQ_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication from a condition to a consequence in the following cycle.
`define MIQ_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/miq_pkg.sv */
// -----------------------------------------------------------------------------
// Middle insert queue package
// Widths, operation and status codes, and the command word shared by the cells.
// -----------------------------------------------------------------------------
package miq_pkg;

    localparam int DATA_W       = 64;
    localparam int FUNC_W       = 2;
    localparam int STATUS_W     = 2;
    localparam int CAPACITY_DEF = 1024;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic [FUNC_W-1:0]        func_t;
    typedef logic [STATUS_W-1:0]      status_t;

    localparam func_t FUNC_APPEND = 2'd0;
    localparam func_t FUNC_POP    = 2'd1;
    localparam func_t FUNC_MIDDLE = 2'd2;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        data_t    value;
    } cell_cmd_t;

endpackage

/* rtl/core/miq_if.sv */
// -----------------------------------------------------------------------------
// Middle insert queue channels
// Request and response handshake interfaces with source and sink modports.
// -----------------------------------------------------------------------------
interface miq_req_if;
    import miq_pkg::*;

    logic  valid;
    logic  ready;
    func_t func;
    data_t value;

    modport source (output valid, output func, output value, input ready);
    modport sink   (input valid, input func, input value, output ready);
endinterface

interface miq_rsp_if;
    import miq_pkg::*;

    logic    valid;
    logic    ready;
    data_t   front_value;
    status_t status;

    modport source (output valid, output front_value, output status, input ready);
    modport sink   (input valid, input front_value, input status, output ready);
endinterface

/* rtl/core/middle_insert_queue_top.sv */
// -----------------------------------------------------------------------------
// Middle insert queue
// Bounded queue of signed 64-bit words with append, pop and middle insert.
// -----------------------------------------------------------------------------
// The req channel takes one word per operation: func selects append at the
// back, pop from the front or insert in the middle, and value is the entry
// for the inserting operations. A middle insert on n entries places the word
// behind the first ceil(n/2) entries. The rsp channel returns a word for every
// pop (the front entry, or status empty) and for every insert into a full
// queue (status full, dropped); successful inserts return nothing.
// Each operation first registers the request word; when it executes, every
// cell of the row loads, holds or takes a neighbour's entry. A response is
// registered in the output register as its request executes. A new request
// is only taken once the registered request before it has executed.
// While a response waits on a stalled receiver the next request is still
// taken; it only waits if it would itself produce a response.
// Reset clears the fill count and the handshake state; the cells keep
// undefined data, which is never read before it is written.
// -----------------------------------------------------------------------------
module middle_insert_queue_top #(
    parameter int CAPACITY = miq_pkg::CAPACITY_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    miq_req_if.sink   req,
    miq_rsp_if.source rsp
);
    import miq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    cell_cmd_t        cell_cmd;
    logic [CNT_W-1:0] cell_pos;
    data_t            cell_data [CAPACITY];

    miq_ctrl #(
        .CAPACITY (CAPACITY),
        .CNT_W    (CNT_W)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .front_data (cell_data[0]),
        .cell_cmd   (cell_cmd),
        .cell_pos   (cell_pos)
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        data_t left_data;
        data_t right_data;

        if (i == 0)
        begin : g_first
            assign left_data = cell_cmd.value;
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        miq_cell #(
            .CNT_W (CNT_W),
            .IDX   (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cell_cmd),
            .pos        (cell_pos),
            .left_data  (left_data),
            .right_data (right_data),
            .data       (cell_data[i])
        );
    end

endmodule

/* rtl/core/miq_cell.sv */
// -----------------------------------------------------------------------------
// Middle insert queue cell
// Holds one queue entry and takes a new value from the command or a neighbour.
// -----------------------------------------------------------------------------
module miq_cell #(
    parameter int CNT_W = 11,
    parameter int IDX   = 0
) (
    input  logic               clk,
    input  miq_pkg::cell_cmd_t cmd,
    input  logic [CNT_W-1:0]   pos,
    input  miq_pkg::data_t     left_data,
    input  miq_pkg::data_t     right_data,
    output miq_pkg::data_t     data
);
    import miq_pkg::*;

    localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

    data_t data_reg;
    data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (cmd.op)
            CELL_HOLD:
            begin
                data_next = data_reg;
            end
            CELL_LOAD:
            begin
                if (MY_IDX == pos)
                begin
                    data_next = cmd.value;
                end
            end
            CELL_INSERT:
            begin
                if (MY_IDX == pos)
                begin
                    data_next = cmd.value;
                end
                else if (MY_IDX > pos)
                begin
                    data_next = left_data;
                end
            end
            CELL_SHIFT:
            begin
                data_next = right_data;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

/* rtl/core/miq_ctrl.sv */
// -----------------------------------------------------------------------------
// Middle insert queue control
// Registers requests, tracks the fill count, drives the cell row and responses.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module miq_ctrl #(
    parameter int CAPACITY = miq_pkg::CAPACITY_DEF,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    miq_req_if.sink            req,
    miq_rsp_if.source          rsp,
    input  miq_pkg::data_t     front_data,
    output miq_pkg::cell_cmd_t cell_cmd,
    output logic [CNT_W-1:0]   cell_pos
);
    import miq_pkg::*;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    logic             cmd_valid_reg;
    logic             cmd_valid_next;
    func_t            cmd_func_reg;
    data_t            cmd_value_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    data_t            rsp_data_reg;
    data_t            rsp_data_next;
    status_t          rsp_status_reg;
    status_t          rsp_status_next;

    logic             is_insert;
    logic             full;
    logic             empty;
    logic             needs_rsp;
    logic             exec;
    logic [CNT_W:0]   n_plus;

    assign is_insert = (cmd_func_reg == FUNC_APPEND) || (cmd_func_reg == FUNC_MIDDLE);
    assign full      = (count_reg == CAP);
    assign empty     = (count_reg == '0);
    assign needs_rsp = (cmd_func_reg == FUNC_POP) || (is_insert && full);
    assign exec      = cmd_valid_reg && (!needs_rsp || !rsp_valid_reg || rsp.ready);
    assign n_plus    = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};

    assign req.ready = !cmd_valid_reg;

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (exec)
        begin
            cmd_valid_next = 1'b0;
        end
        else if (req.valid && req.ready)
        begin
            cmd_valid_next = 1'b1;
        end
    end

    always_comb
    begin
        cell_cmd.op    = CELL_HOLD;
        cell_cmd.value = cmd_value_reg;
        cell_pos       = count_reg;
        count_next     = count_reg;
        if (exec)
        begin
            priority if (is_insert && !full)
            begin
                count_next = count_reg + {{(CNT_W-1){1'b0}}, 1'b1};
                if (cmd_func_reg == FUNC_APPEND)
                begin
                    cell_cmd.op = CELL_LOAD;
                end
                else
                begin
                    cell_cmd.op = CELL_INSERT;
                    cell_pos    = n_plus[CNT_W:1];
                end
            end
            else if (cmd_func_reg == FUNC_POP && !empty)
            begin
                cell_cmd.op = CELL_SHIFT;
                count_next  = count_reg - {{(CNT_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                cell_cmd.op = CELL_HOLD;
            end
        end
    end

    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg;
        rsp_data_next   = rsp_data_reg;
        rsp_status_next = rsp_status_reg;
        if (exec && needs_rsp)
        begin
            rsp_valid_next = 1'b1;
            priority if (is_insert)
            begin
                rsp_data_next   = '0;
                rsp_status_next = STATUS_FULL;
            end
            else if (empty)
            begin
                rsp_data_next   = '0;
                rsp_status_next = STATUS_EMPTY;
            end
            else
            begin
                rsp_data_next   = front_data;
                rsp_status_next = STATUS_OK;
            end
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            cmd_func_reg  <= req.func;
            cmd_value_reg <= req.value;
        end
        rsp_data_reg   <= rsp_data_next;
        rsp_status_reg <= rsp_status_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.front_value = rsp_data_reg;
    assign rsp.status      = rsp_status_reg;

    `MIQ_ASSERT(a_count_bound, count_reg <= CAP, "Fill count exceeds the capacity.")
    `MIQ_ASSERT(a_rsp_zero, !rsp_valid_reg || rsp_status_reg == STATUS_OK || rsp_data_reg == '0,
                "A failed response carries a non-zero value.")
    `MIQ_ASSERT_NEXT(a_pop_count, exec && cmd_func_reg == FUNC_POP && !empty,
                     count_reg == $past(count_reg) - {{(CNT_W-1){1'b0}}, 1'b1},
                     "A successful pop did not lower the fill count by one.")
    `MIQ_ASSERT_NEXT(a_full_hold, exec && is_insert && full,
                     count_reg == $past(count_reg) && rsp_status_reg == STATUS_FULL,
                     "An insert into a full queue changed the fill count.")

endmodule
